FILE: hdl/rtu_pkg.sv
// shared constants and types for the route table update unit
package rtu_pkg;

  // default sizing
  localparam int MAX_ROUTES_DEF = 64;
  localparam int IFC_BITS_DEF   = 4;

  // field widths
  localparam int PREFIX_W = 64;
  localparam int HOP_W    = 64;
  localparam int LEN_W    = 8;
  localparam int METRIC_W = 8;
  localparam int ORIGIN_W = 8;
  localparam int STAMP_W  = 32;
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 6;
  localparam int TOTAL_W  = 7;

  // result action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOWERED   = 2'd0,
    ACT_REFRESHED = 2'd1,
    ACT_INSERTED  = 2'd2,
    ACT_FULL      = 2'd3
  } action_t;

endpackage

FILE: hdl/rtu_ram.sv
// generic single write port, single read port ram with registered read
module rtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/route_table_update_unit.sv
// Route table update unit: distance-vector route table update for IPv6 routes.
//
// One item on the item channel offers a route (prefix, length, metric, next
// hop, interface, origin, time). The unit scans the stored entries from the
// newest slot down to the oldest for the same prefix, length and interface.
// The first match with a higher stored metric takes the new metric and time,
// the first match with an equal metric gets its time refreshed; otherwise the
// route is appended in the next free slot, or the table-full action is given.
// Each item yields exactly one item on the result channel (action, slot,
// number of stored entries).
// The scan reads one entry a cycle from the single read port of the entry
// ram, which sets the rate, and a match stops the scan early. item_stall is
// high from acceptance until the result is loaded into the output register.
// Reset empties the table at once (fill count goes to zero, no clearing pass).
// A stalled result holds; the next item is accepted meanwhile and its result
// waits in the sequencer until the output register frees up.
module route_table_update_unit #(
  parameter int MAX_ROUTES     = rtu_pkg::MAX_ROUTES_DEF,
  parameter int INTERFACE_BITS = rtu_pkg::IFC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [rtu_pkg::PREFIX_W-1:0]  prefix_high,
  input  logic [rtu_pkg::PREFIX_W-1:0]  prefix_low,
  input  logic [rtu_pkg::LEN_W-1:0]     prefix_length,
  input  logic [rtu_pkg::METRIC_W-1:0]  route_metric,
  input  logic [rtu_pkg::HOP_W-1:0]     hop_high,
  input  logic [rtu_pkg::HOP_W-1:0]     hop_low,
  input  logic [INTERFACE_BITS-1:0]     interface_id,
  input  logic [rtu_pkg::ORIGIN_W-1:0]  origin_code,
  input  logic [rtu_pkg::STAMP_W-1:0]   now_seconds,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output rtu_pkg::action_t              action,
  output logic [rtu_pkg::INDEX_W-1:0]   entry_index,
  output logic [rtu_pkg::TOTAL_W-1:0]   entry_total
);

  import rtu_pkg::*;

  localparam int SW = $clog2(MAX_ROUTES);
  localparam int TW = $clog2(MAX_ROUTES + 1);

  // entry word layout, stamp at the bottom
  localparam int ORIGIN_LSB = STAMP_W;
  localparam int HOPL_LSB   = ORIGIN_LSB + ORIGIN_W;
  localparam int HOPH_LSB   = HOPL_LSB + HOP_W;
  localparam int METRIC_LSB = HOPH_LSB + HOP_W;
  localparam int IFC_LSB    = METRIC_LSB + METRIC_W;
  localparam int LEN_LSB    = IFC_LSB + INTERFACE_BITS;
  localparam int PFXL_LSB   = LEN_LSB + LEN_W;
  localparam int PFXH_LSB   = PFXL_LSB + PREFIX_W;
  localparam int WORD_W     = PFXH_LSB + PREFIX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // sequencer registers
  logic [TW-1:0] stored_total;
  logic [TW-1:0] scan_cnt;
  logic          rd_pend;
  logic [SW-1:0] rd_slot;
  action_t       res_act;
  logic [SW-1:0] res_slot;

  // item held for the scan
  logic [PREFIX_W-1:0]       pfx_hi;
  logic [PREFIX_W-1:0]       pfx_lo;
  logic [LEN_W-1:0]          len;
  logic [METRIC_W-1:0]       metric;
  logic [HOP_W-1:0]          hop_hi;
  logic [HOP_W-1:0]          hop_lo;
  logic [INTERFACE_BITS-1:0] ifc;
  logic [ORIGIN_W-1:0]       origin;
  logic [STAMP_W-1:0]        stamp;

  // ram side
  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_q;

  // compare unit and scan control
  logic [METRIC_W-1:0] q_metric;
  logic                key_match;
  logic                hit;
  logic                issue;
  logic                done_scan;
  logic                full;
  logic                insert_go;
  logic [TW-1:0]       scan_dec;

  assign item_stall = (state != S_IDLE);

  // compare the entry read last cycle against the held item
  always_comb begin
    q_metric  = ram_q[METRIC_LSB +: METRIC_W];
    key_match = (ram_q[PFXH_LSB +: PREFIX_W] == pfx_hi) &&
                (ram_q[PFXL_LSB +: PREFIX_W] == pfx_lo) &&
                (ram_q[LEN_LSB +: LEN_W] == len) &&
                (ram_q[IFC_LSB +: INTERFACE_BITS] == ifc);
    hit       = (state == S_SCAN) && rd_pend && key_match && (metric <= q_metric);
    scan_dec  = scan_cnt - TW'(1);
    issue     = (state == S_SCAN) && !hit && (scan_cnt != '0);
    done_scan = (state == S_SCAN) && !rd_pend && (scan_cnt == '0);
    full      = (stored_total == TW'(MAX_ROUTES));
    insert_go = done_scan && !full;
  end

  // ram access: read newest to oldest, write back on hit or append
  always_comb begin
    ram_re    = issue;
    ram_we    = hit || insert_go;
    ram_waddr = hit ? rd_slot : stored_total[SW-1:0];
    if (hit) begin
      // keep key, hop and origin; new metric is the lower or equal one
      ram_wdata = {ram_q[WORD_W-1:IFC_LSB], metric, ram_q[METRIC_LSB-1:STAMP_W], stamp};
    end else begin
      ram_wdata = {pfx_hi, pfx_lo, len, ifc, metric, hop_hi, hop_lo, origin, stamp};
    end
  end

  rtu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROUTES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_dec[SW-1:0]),
    .rdata (ram_q)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_total <= '0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // taken result clears unless a new one is loaded this cycle
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            pfx_hi   <= prefix_high;
            pfx_lo   <= prefix_low;
            len      <= prefix_length;
            metric   <= route_metric;
            hop_hi   <= hop_high;
            hop_lo   <= hop_low;
            ifc      <= interface_id;
            origin   <= origin_code;
            stamp    <= now_seconds;
            scan_cnt <= stored_total;
            rd_pend  <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_act  <= (metric < q_metric) ? ACT_LOWERED : ACT_REFRESHED;
            res_slot <= rd_slot;
            state    <= S_FINISH;
          end else if (done_scan) begin
            if (full) begin
              res_act  <= ACT_FULL;
              res_slot <= '0;
            end else begin
              res_act      <= ACT_INSERTED;
              res_slot     <= stored_total[SW-1:0];
              stored_total <= stored_total + TW'(1);
            end
            state <= S_FINISH;
          end else begin
            rd_pend <= issue;
            if (issue) begin
              rd_slot  <= scan_dec[SW-1:0];
              scan_cnt <= scan_dec;
            end
          end
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            action       <= res_act;
            entry_index  <= INDEX_W'(res_slot);
            entry_total  <= TOTAL_W'(stored_total);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // fill count never passes the table size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    stored_total <= TW'(MAX_ROUTES))
    else $error("stored entry count exceeds table size");

  // a full result reports a full table
  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (result_valid && action == ACT_FULL) |-> entry_total == TOTAL_W'(MAX_ROUTES))
    else $error("table full reported with a partial table");

  // an append grows the table by exactly one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    insert_go |=> stored_total == $past(stored_total) + TW'(1))
    else $error("append did not advance the fill count");

endmodule

FILE: bench/route_table_checker.sv
// checker for the route table update unit: predicts each result and compares it
`timescale 1ns / 1ps

module route_table_checker #(
  parameter int MAX_ROUTES     = rtu_pkg::MAX_ROUTES_DEF,
  parameter int INTERFACE_BITS = rtu_pkg::IFC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic [rtu_pkg::PREFIX_W-1:0]  prefix_high,
  input  logic [rtu_pkg::PREFIX_W-1:0]  prefix_low,
  input  logic [rtu_pkg::LEN_W-1:0]     prefix_length,
  input  logic [rtu_pkg::METRIC_W-1:0]  route_metric,
  input  logic [INTERFACE_BITS-1:0]     interface_id,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  rtu_pkg::action_t              action,
  input  logic [rtu_pkg::INDEX_W-1:0]   entry_index,
  input  logic [rtu_pkg::TOTAL_W-1:0]   entry_total,
  output int                            fail_count,
  output int                            outstanding
);

  typedef struct packed {
    rtu_pkg::action_t                 act;
    logic [rtu_pkg::INDEX_W-1:0]      slot;
    logic [rtu_pkg::TOTAL_W-1:0]      total;
  } route_result_t;

  // shadow copy of the route table (only what decides the results)
  logic                          slot_used   [MAX_ROUTES];
  logic [rtu_pkg::PREFIX_W-1:0]  slot_pfx_hi [MAX_ROUTES];
  logic [rtu_pkg::PREFIX_W-1:0]  slot_pfx_lo [MAX_ROUTES];
  logic [rtu_pkg::LEN_W-1:0]     slot_len    [MAX_ROUTES];
  logic [rtu_pkg::METRIC_W-1:0]  slot_metric [MAX_ROUTES];
  logic [INTERFACE_BITS-1:0]     slot_ifc    [MAX_ROUTES];
  int                            route_count;

  route_result_t                 pending_results[$];
  int                            mismatches = 0;

  // newest-first search, then append or report a full table
  function automatic route_result_t apply_route_update(
    input logic [rtu_pkg::PREFIX_W-1:0] p_hi,
    input logic [rtu_pkg::PREFIX_W-1:0] p_lo,
    input logic [rtu_pkg::LEN_W-1:0]    len,
    input logic [rtu_pkg::METRIC_W-1:0] metric,
    input logic [INTERFACE_BITS-1:0]    ifc
  );
    route_result_t res;
    int            s;
    for (s = route_count - 1; s >= 0; s--) begin
      if (slot_used[s] && slot_pfx_hi[s] == p_hi && slot_pfx_lo[s] == p_lo &&
          slot_len[s] == len && slot_ifc[s] == ifc) begin
        // better metric replaces the stored one
        if (metric < slot_metric[s]) begin
          slot_metric[s] = metric;
          res.act   = rtu_pkg::ACT_LOWERED;
          res.slot  = s[rtu_pkg::INDEX_W-1:0];
          res.total = route_count[rtu_pkg::TOTAL_W-1:0];
          return res;
        end
        // same metric only refreshes the stamp
        if (metric == slot_metric[s]) begin
          res.act   = rtu_pkg::ACT_REFRESHED;
          res.slot  = s[rtu_pkg::INDEX_W-1:0];
          res.total = route_count[rtu_pkg::TOTAL_W-1:0];
          return res;
        end
      end
    end
    // no room left, table untouched
    if (route_count >= MAX_ROUTES) begin
      res.act   = rtu_pkg::ACT_FULL;
      res.slot  = '0;
      res.total = route_count[rtu_pkg::TOTAL_W-1:0];
      return res;
    end
    slot_used[route_count]   = 1'b1;
    slot_pfx_hi[route_count] = p_hi;
    slot_pfx_lo[route_count] = p_lo;
    slot_len[route_count]    = len;
    slot_metric[route_count] = metric;
    slot_ifc[route_count]    = ifc;
    res.act   = rtu_pkg::ACT_INSERTED;
    res.slot  = route_count[rtu_pkg::INDEX_W-1:0];
    route_count++;
    res.total = route_count[rtu_pkg::TOTAL_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin
    route_result_t want;
    if (rst) begin
      route_count = 0;
      for (int k = 0; k < MAX_ROUTES; k++) slot_used[k] = 1'b0;
      pending_results.delete();
    end else begin
      if (item_valid && !item_stall) begin
        pending_results.push_back(apply_route_update(prefix_high, prefix_low,
                                                     prefix_length, route_metric,
                                                     interface_id));
      end
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual action %0d slot %0d total %0d",
                   $time, action, entry_index, entry_total);
        end else begin
          want = pending_results.pop_front();
          check_field("action", want.act, action);
          check_field("entry_index", want.slot, entry_index);
          check_field("entry_total", want.total, entry_total);
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

FILE: bench/testbench.sv
// top of the bench: clock, reset, route stimulus, result stalls and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int IFC_W       = rtu_pkg::IFC_BITS_DEF;
  localparam int RANDOM_ROUTES = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [rtu_pkg::PREFIX_W-1:0] hi;
    logic [rtu_pkg::PREFIX_W-1:0] lo;
    logic [rtu_pkg::LEN_W-1:0]    len;
    logic [IFC_W-1:0]             ifc;
  } route_key_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          item_valid;
  logic                          item_stall;
  logic [rtu_pkg::PREFIX_W-1:0]  prefix_high;
  logic [rtu_pkg::PREFIX_W-1:0]  prefix_low;
  logic [rtu_pkg::LEN_W-1:0]     prefix_length;
  logic [rtu_pkg::METRIC_W-1:0]  route_metric;
  logic [rtu_pkg::HOP_W-1:0]     hop_high;
  logic [rtu_pkg::HOP_W-1:0]     hop_low;
  logic [IFC_W-1:0]              interface_id;
  logic [rtu_pkg::ORIGIN_W-1:0]  origin_code;
  logic [rtu_pkg::STAMP_W-1:0]   now_seconds;
  logic                          result_valid;
  logic                          result_stall;
  rtu_pkg::action_t              action;
  logic [rtu_pkg::INDEX_W-1:0]   entry_index;
  logic [rtu_pkg::TOTAL_W-1:0]   entry_total;

  int                            fail_count;
  int                            outstanding;

  // pacing controls shared by the sender and receiver
  bit                            calm      = 1'b0;
  bit                            hold_req  = 1'b0;
  bit                            hold_done = 1'b0;

  route_key_t                    known_keys[$];

  always #4 clk = ~clk;

  route_table_update_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .prefix_high(prefix_high), .prefix_low(prefix_low),
    .prefix_length(prefix_length), .route_metric(route_metric),
    .hop_high(hop_high), .hop_low(hop_low), .interface_id(interface_id),
    .origin_code(origin_code), .now_seconds(now_seconds),
    .result_valid(result_valid), .result_stall(result_stall),
    .action(action), .entry_index(entry_index), .entry_total(entry_total)
  );

  route_table_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .prefix_high(prefix_high), .prefix_low(prefix_low),
    .prefix_length(prefix_length), .route_metric(route_metric),
    .interface_id(interface_id),
    .result_valid(result_valid), .result_stall(result_stall),
    .action(action), .entry_index(entry_index), .entry_total(entry_total),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present one route and hold it until the unit takes it
  task automatic offer_route(
    input route_key_t                   key,
    input logic [rtu_pkg::METRIC_W-1:0] metric,
    input logic [rtu_pkg::HOP_W-1:0]    h_hi,
    input logic [rtu_pkg::HOP_W-1:0]    h_lo,
    input logic [rtu_pkg::ORIGIN_W-1:0] origin,
    input logic [rtu_pkg::STAMP_W-1:0]  stamp
  );
    int gap;
    gap = (calm || (hold_req && !hold_done)) ? 0 : idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    prefix_high   <= key.hi;
    prefix_low    <= key.lo;
    prefix_length <= key.len;
    route_metric  <= metric;
    hop_high      <= h_hi;
    hop_low       <= h_lo;
    interface_id  <= key.ifc;
    origin_code   <= origin;
    now_seconds   <= stamp;
    item_valid    <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int run;
    result_stall = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        result_stall <= 1'b1;
        for (int held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        result_stall <= 1'b0;
        @(negedge clk);
      end else begin
        run = idle_len();
        if (run > 0) begin
          result_stall <= 1'b1;
          repeat (run) @(negedge clk);
        end
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // route stimulus and verdict
  initial begin
    route_key_t                   k_zero;
    route_key_t                   k_ones;
    route_key_t                   key;
    logic [rtu_pkg::METRIC_W-1:0] metric;
    rst           = 1'b1;
    item_valid    = 1'b0;
    prefix_high   = '0;
    prefix_low    = '0;
    prefix_length = '0;
    route_metric  = '0;
    hop_high      = '0;
    hop_low       = '0;
    interface_id  = '0;
    origin_code   = '0;
    now_seconds   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, lower / refresh / pass-over, near misses
    k_zero = '{hi: '0, lo: '0, len: '0, ifc: '0};
    k_ones = '{hi: '1, lo: '1, len: 8'hFF, ifc: '1};
    offer_route(k_zero, 8'd0, '0, '0, 8'h00, 32'h0);
    offer_route(k_ones, 8'hFF, '1, '1, 8'hFF, 32'hFFFF_FFFF);
    offer_route(k_ones, 8'hFF, rand64(), rand64(), 8'h5A, 32'd100);
    offer_route(k_ones, 8'd100, rand64(), rand64(), 8'hA5, 32'd200);
    // worse metric skips the match and appends a duplicate
    offer_route(k_ones, 8'd200, rand64(), rand64(), 8'h01, 32'd300);
    offer_route(k_ones, 8'd200, rand64(), rand64(), 8'h02, 32'd400);
    offer_route(k_ones, 8'd150, rand64(), rand64(), 8'h03, 32'd500);
    offer_route(k_ones, 8'd100, rand64(), rand64(), 8'h04, 32'd600);
    offer_route(k_ones, 8'd90, rand64(), rand64(), 8'h05, 32'd700);
    // same prefix with another interface or length, then one prefix bit flipped
    key = k_ones;
    key.ifc = 4'hE;
    offer_route(key, 8'd10, rand64(), rand64(), 8'h06, 32'd800);
    key = k_ones;
    key.len = 8'd128;
    offer_route(key, 8'd10, rand64(), rand64(), 8'h07, 32'd900);
    key = k_ones;
    key.lo[0] = 1'b0;
    offer_route(key, 8'd10, rand64(), rand64(), 8'h08, 32'd1000);
    offer_route(k_zero, 8'd0, rand64(), rand64(), 8'h09, 32'd1100);
    offer_route(k_zero, 8'd1, rand64(), rand64(), 8'h0A, 32'd1200);
    key = '{hi: rand64(), lo: rand64(), len: 8'd129, ifc: 4'h7};
    offer_route(key, 8'd0, rand64(), rand64(), 8'h80, 32'h8000_0000);
    offer_route(key, 8'd0, rand64(), rand64(), 8'h81, 32'h8000_0001);
    known_keys.push_back(k_zero);
    known_keys.push_back(k_ones);
    known_keys.push_back(key);

    // random: mostly known keys so matches happen, some fresh keys
    for (int n = 0; n < RANDOM_ROUTES; n++) begin
      if (n == 120) hold_req = 1'b1;
      calm = (n >= 200 && n < 260);
      if ($urandom_range(0, 3) == 0) begin
        key.hi  = rand64();
        key.lo  = rand64();
        key.len = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 128));
        key.ifc = IFC_W'($urandom);
        metric  = 8'($urandom);
        if (known_keys.size() < 48) known_keys.push_back(key);
        else known_keys[$urandom_range(0, 47)] = key;
      end else begin
        key    = known_keys[$urandom_range(0, known_keys.size() - 1)];
        metric = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      end
      offer_route(key, metric, rand64(), rand64(), 8'($urandom), $urandom);
    end
    item_valid <= 1'b0;
    calm = 1'b0;

    // drain the remaining results, then let the unit settle
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
